### design/tlfqs_pkg.sv
// shared types and constants for the three-level feedback queue scheduler
// no dependencies; imported by tlfqs_unit, the scheduler top and the testbench
package tlfqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TICK_BITS_DEF   = 32;

    // command codes
    localparam logic [1:0] OP_READY = 2'd0;
    localparam logic [1:0] OP_PICK  = 2'd1;
    localparam logic [1:0] OP_AGE   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_THR  = 2'd0;
    localparam logic [1:0] CFG_HIGH_THR = 2'd1;
    localparam logic [1:0] CFG_AGE_LIM  = 2'd2;
    localparam logic [1:0] CFG_AGE_STEP = 2'd3;

    localparam logic [7:0]  LOW_THR_RST  = 8'd49;
    localparam logic [7:0]  HIGH_THR_RST = 8'd99;
    localparam logic [15:0] AGE_LIM_RST  = 16'd1500;
    localparam logic [7:0]  AGE_STEP_RST = 8'd10;

    // memory regions: levels one to three, then scratch
    localparam logic [1:0] REG_L1      = 2'd0;
    localparam logic [1:0] REG_L2      = 2'd1;
    localparam logic [1:0] REG_L3      = 2'd2;
    localparam logic [1:0] REG_SCRATCH = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         thread_id;
        logic [7:0]         priority_req;
        logic signed [31:0] remaining_burst;
        logic [31:0]        now_tick;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] picked_id;
        logic [1:0] picked_level;
    } out_item_t;

    typedef struct packed {
        logic       ahead;
        logic       aged;
        logic [7:0] new_prio;
    } unit_res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PICK_HEAD,
        ST_PICK_SHIFT,
        ST_INS_START,
        ST_INS_CMP,
        ST_INS_HEAD,
        ST_A3_START,
        ST_A3_READ,
        ST_A3_VISIT,
        ST_A3_NEXT,
        ST_A3_DRD,
        ST_A3_DWR,
        ST_A2_START,
        ST_A2_CRD,
        ST_A2_CWR,
        ST_A2_READ,
        ST_A2_VISIT,
        ST_A2_NEXT,
        ST_FIN
    } state_t;

endpackage

### design/tlfqs_ram.sv
// generic single write port ram with registered read
// no dependencies
module tlfqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/tlfqs_unit.sv
// shared order compare and aging unit
// depends on tlfqs_pkg
module tlfqs_unit import tlfqs_pkg::*; #(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic                 prio_order,
    input  logic [7:0]           a_id,
    input  logic [7:0]           a_prio,
    input  logic signed [31:0]   a_key,
    input  logic [7:0]           b_id,
    input  logic [7:0]           b_prio,
    input  logic signed [31:0]   b_key,
    input  logic [TICK_BITS-1:0] b_stamp,
    input  logic [TICK_BITS-1:0] now,
    input  logic [15:0]          age_limit,
    input  logic [7:0]           age_step,
    output unit_res_t            res
);

    logic [TICK_BITS-1:0] wait_ticks;
    logic [8:0]           prio_sum;

    always_comb begin
        // a goes strictly ahead of b
        if (prio_order) begin
            res.ahead = (a_prio != b_prio) ? (a_prio > b_prio) : (a_id < b_id);
        end else begin
            res.ahead = (a_key != b_key) ? (a_key < b_key) : (a_id < b_id);
        end
        wait_ticks   = now - b_stamp;
        res.aged     = wait_ticks > TICK_BITS'(age_limit);
        prio_sum     = {1'b0, b_prio} + {1'b0, age_step};
        res.new_prio = prio_sum[8] ? 8'hff : prio_sum[7:0];
    end

endmodule

### design/three_level_feedback_queue_scheduler.sv
// three-level feedback queue scheduler: one sequencer over one ram and one compare/age unit
// aging walks level three, then level two, with sorted inserts into levels one and two
// one item at a time; the single ram port pair sets the pace of every walk
// reset (aresetn low, synchronous) empties all levels and loads default thresholds
// depends on tlfqs_pkg, tlfqs_ram, tlfqs_unit
module three_level_feedback_queue_scheduler import tlfqs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TICK_BITS   = TICK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W  = IDX_W + 2;
    localparam int RAM_DEP = 4 << IDX_W;
    localparam int SLOT_W  = 48 + TICK_BITS;

    // sequencer state
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;           // where an insert returns to
    logic [1:0]       lvl_reg, lvl_next; // level being inserted into or picked from
    logic [IDX_W-1:0] idx_reg, idx_next; // walk index of insert and pick
    logic [CNT_W-1:0] vidx_reg, vidx_next; // visit index of aging
    logic [CNT_W-1:0] n_reg, n_next;     // entries to visit in an aging pass
    logic [CNT_W-1:0] d_reg, d_next;     // deferred level three entries
    logic [SLOT_W-1:0] ins_reg, ins_next;
    logic [TICK_BITS-1:0] now_reg, now_next;
    out_item_t res_reg, res_next;

    // per level entry counts
    logic [CNT_W-1:0] cnt0_reg, cnt0_next;
    logic [CNT_W-1:0] cnt1_reg, cnt1_next;
    logic [CNT_W-1:0] cnt2_reg, cnt2_next;

    // output register
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    // configuration
    logic [7:0]  low_thr_reg, high_thr_reg, age_step_reg;
    logic [15:0] age_lim_reg;

    // ram port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [SLOT_W-1:0] wr_data, rd_data;

    // fields of the entry just read and of the entry being inserted
    logic [7:0]           rd_id, rd_prio, ins_id, ins_prio;
    logic signed [31:0]   rd_key, ins_key;
    logic [TICK_BITS-1:0] rd_stamp;
    logic [SLOT_W-1:0]    aged_slot, new_slot;
    logic [CNT_W-1:0]     cnt_sel;
    logic [CNT_W-1:0]     depth_c;
    logic [1:0]           new_lvl;
    logic                 bump_inc, bump_dec;
    unit_res_t            u;

    assign rd_id    = rd_data[SLOT_W-1 -: 8];
    assign rd_prio  = rd_data[SLOT_W-9 -: 8];
    assign rd_key   = rd_data[TICK_BITS+31 -: 32];
    assign rd_stamp = rd_data[TICK_BITS-1:0];
    assign ins_id   = ins_reg[SLOT_W-1 -: 8];
    assign ins_prio = ins_reg[SLOT_W-9 -: 8];
    assign ins_key  = ins_reg[TICK_BITS+31 -: 32];

    // an aged entry gains priority and is stamped with the current tick
    assign aged_slot = {rd_id, u.new_prio, rd_key, now_reg};
    assign depth_c   = CNT_W'(QUEUE_DEPTH);

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    tlfqs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (RAM_DEP)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // level one sorts by burst key, level two by priority
    tlfqs_unit #(
        .TICK_BITS (TICK_BITS)
    ) u_unit (
        .prio_order (lvl_reg[0]),
        .a_id       (ins_id),
        .a_prio     (ins_prio),
        .a_key      (ins_key),
        .b_id       (rd_id),
        .b_prio     (rd_prio),
        .b_key      (rd_key),
        .b_stamp    (rd_stamp),
        .now        (now_reg),
        .age_limit  (age_lim_reg),
        .age_step   (age_step_reg),
        .res        (u)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg  <= LOW_THR_RST;
            high_thr_reg <= HIGH_THR_RST;
            age_lim_reg  <= AGE_LIM_RST;
            age_step_reg <= AGE_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOW_THR:  low_thr_reg  <= cfg_data[7:0];
                CFG_HIGH_THR: high_thr_reg <= cfg_data[7:0];
                CFG_AGE_LIM:  age_lim_reg  <= cfg_data;
                CFG_AGE_STEP: age_step_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_FIN;
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt0_reg      <= cnt0_next;
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge aclk) begin
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        vidx_reg <= vidx_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        ins_reg  <= ins_next;
        now_reg  <= now_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        vidx_next      = vidx_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        ins_next       = ins_reg;
        now_next       = now_reg;
        res_next       = res_reg;
        cnt0_next      = cnt0_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;
        rd_addr        = '0;
        bump_inc       = 1'b0;
        bump_dec       = 1'b0;
        new_slot       = {s_data.thread_id, s_data.priority_req,
                          s_data.remaining_burst, TICK_BITS'(s_data.now_tick)};
        new_lvl        = REG_L3;

        case (lvl_reg)
            REG_L1:  cnt_sel = cnt0_reg;
            REG_L2:  cnt_sel = cnt1_reg;
            default: cnt_sel = cnt2_reg;
        endcase

        // result handed over, output register drains
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next = TICK_BITS'(s_data.now_tick);
                    res_next = '0;
                    case (s_data.opcode)
                        OP_READY: begin
                            // high threshold wins even when thresholds cross
                            if (s_data.priority_req > high_thr_reg) begin
                                new_lvl = REG_L1;
                            end else if (s_data.priority_req > low_thr_reg) begin
                                new_lvl = REG_L2;
                            end
                            ins_next = new_slot;
                            lvl_next = new_lvl;
                            ret_next = ST_FIN;
                            case (new_lvl)
                                REG_L1: begin
                                    if (cnt0_reg >= depth_c) begin
                                        res_next.status = STAT_FULL;
                                        state_next      = ST_FIN;
                                    end else begin
                                        state_next = ST_INS_START;
                                    end
                                end
                                REG_L2: begin
                                    if (cnt1_reg >= depth_c) begin
                                        res_next.status = STAT_FULL;
                                        state_next      = ST_FIN;
                                    end else begin
                                        state_next = ST_INS_START;
                                    end
                                end
                                default: begin
                                    // fifo level: append at the tail
                                    if (cnt2_reg >= depth_c) begin
                                        res_next.status = STAT_FULL;
                                    end else begin
                                        wr_en     = 1'b1;
                                        wr_addr   = {REG_L3, cnt2_reg[IDX_W-1:0]};
                                        wr_data   = new_slot;
                                        cnt2_next = cnt2_reg + 1'b1;
                                    end
                                    state_next = ST_FIN;
                                end
                            endcase
                        end
                        OP_PICK: begin
                            if (cnt0_reg != '0) begin
                                new_lvl = REG_L1;
                            end else if (cnt1_reg != '0) begin
                                new_lvl = REG_L2;
                            end
                            if (cnt0_reg == '0 && cnt1_reg == '0 && cnt2_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                                state_next      = ST_FIN;
                            end else begin
                                lvl_next   = new_lvl;
                                rd_addr    = {new_lvl, IDX_W'(0)};
                                state_next = ST_PICK_HEAD;
                            end
                        end
                        OP_AGE: begin
                            state_next = ST_A3_START;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            // pick: take the head, then shift the rest down one slot
            ST_PICK_HEAD: begin
                res_next.status       = STAT_DONE;
                res_next.picked_id    = rd_id;
                res_next.picked_level = lvl_reg + 2'd1;
                if (cnt_sel == CNT_W'(1)) begin
                    bump_dec   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    idx_next   = IDX_W'(1);
                    rd_addr    = {lvl_reg, IDX_W'(1)};
                    state_next = ST_PICK_SHIFT;
                end
            end
            ST_PICK_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = {lvl_reg, idx_reg - 1'b1};
                if (CNT_W'(idx_reg) + 1'b1 == cnt_sel) begin
                    bump_dec   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = {lvl_reg, idx_reg + 1'b1};
                end
            end

            // sorted insert: walk from the tail, moving up the entries that the new one goes ahead of
            ST_INS_START: begin
                if (cnt_sel == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = {lvl_reg, IDX_W'(0)};
                    wr_data    = ins_reg;
                    bump_inc   = 1'b1;
                    state_next = ret_reg;
                end else begin
                    idx_next   = IDX_W'(cnt_sel - 1'b1);
                    rd_addr    = {lvl_reg, IDX_W'(cnt_sel - 1'b1)};
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = {lvl_reg, idx_reg + 1'b1};
                if (u.ahead) begin
                    if (idx_reg == '0) begin
                        state_next = ST_INS_HEAD;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                        rd_addr  = {lvl_reg, idx_reg - 1'b1};
                    end
                end else begin
                    wr_data    = ins_reg;
                    bump_inc   = 1'b1;
                    state_next = ret_reg;
                end
            end
            ST_INS_HEAD: begin
                wr_en      = 1'b1;
                wr_addr    = {lvl_reg, IDX_W'(0)};
                wr_data    = ins_reg;
                bump_inc   = 1'b1;
                state_next = ret_reg;
            end

            // aging of level three: compact in place, defer aged stay-behinds
            ST_A3_START: begin
                n_next    = cnt2_reg;
                cnt2_next = '0;
                d_next    = '0;
                vidx_next = '0;
                if (cnt2_reg == '0) begin
                    state_next = ST_A2_START;
                end else begin
                    state_next = ST_A3_READ;
                end
            end
            ST_A3_READ: begin
                rd_addr    = {REG_L3, vidx_reg[IDX_W-1:0]};
                state_next = ST_A3_VISIT;
            end
            ST_A3_VISIT: begin
                state_next = ST_A3_NEXT;
                if (!u.aged) begin
                    wr_en     = 1'b1;
                    wr_addr   = {REG_L3, cnt2_reg[IDX_W-1:0]};
                    cnt2_next = cnt2_reg + 1'b1;
                end else if (u.new_prio > low_thr_reg && cnt1_reg < depth_c) begin
                    ins_next   = aged_slot;
                    lvl_next   = REG_L2;
                    ret_next   = ST_A3_NEXT;
                    state_next = ST_INS_START;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = {REG_SCRATCH, d_reg[IDX_W-1:0]};
                    wr_data = aged_slot;
                    d_next  = d_reg + 1'b1;
                end
            end
            ST_A3_NEXT: begin
                if (vidx_reg + 1'b1 == n_reg) begin
                    vidx_next  = '0;
                    state_next = ST_A3_DRD;
                end else begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_A3_READ;
                end
            end
            ST_A3_DRD: begin
                if (vidx_reg == d_reg) begin
                    state_next = ST_A2_START;
                end else begin
                    rd_addr    = {REG_SCRATCH, vidx_reg[IDX_W-1:0]};
                    state_next = ST_A3_DWR;
                end
            end
            ST_A3_DWR: begin
                wr_en      = 1'b1;
                wr_addr    = {REG_L3, cnt2_reg[IDX_W-1:0]};
                cnt2_next  = cnt2_reg + 1'b1;
                vidx_next  = vidx_reg + 1'b1;
                state_next = ST_A3_DRD;
            end

            // aging of level two: copy to scratch, then reinsert one by one
            ST_A2_START: begin
                n_next    = cnt1_reg;
                vidx_next = '0;
                if (cnt1_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_A2_CRD;
                end
            end
            ST_A2_CRD: begin
                rd_addr    = {REG_L2, vidx_reg[IDX_W-1:0]};
                state_next = ST_A2_CWR;
            end
            ST_A2_CWR: begin
                wr_en   = 1'b1;
                wr_addr = {REG_SCRATCH, vidx_reg[IDX_W-1:0]};
                if (vidx_reg + 1'b1 == n_reg) begin
                    cnt1_next  = '0;
                    vidx_next  = '0;
                    state_next = ST_A2_READ;
                end else begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_A2_CRD;
                end
            end
            ST_A2_READ: begin
                rd_addr    = {REG_SCRATCH, vidx_reg[IDX_W-1:0]};
                state_next = ST_A2_VISIT;
            end
            ST_A2_VISIT: begin
                ret_next   = ST_A2_NEXT;
                state_next = ST_INS_START;
                if (u.aged && u.new_prio > high_thr_reg && cnt0_reg < depth_c) begin
                    ins_next = aged_slot;
                    lvl_next = REG_L1;
                end else begin
                    ins_next = u.aged ? aged_slot : rd_data;
                    lvl_next = REG_L2;
                end
            end
            ST_A2_NEXT: begin
                if (vidx_reg + 1'b1 == n_reg) begin
                    state_next = ST_FIN;
                end else begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_A2_READ;
                end
            end

            // hand the result to the output register once it is free
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // count update of the level under work
        if (bump_inc || bump_dec) begin
            case (lvl_reg)
                REG_L1:  cnt0_next = bump_inc ? cnt0_reg + 1'b1 : cnt0_reg - 1'b1;
                REG_L2:  cnt1_next = bump_inc ? cnt1_reg + 1'b1 : cnt1_reg - 1'b1;
                default: cnt2_next = bump_inc ? cnt2_reg + 1'b1 : cnt2_reg - 1'b1;
            endcase
        end
    end

endmodule

### tb/three_level_feedback_queue_scheduler_tb.sv
// testbench for the three-level feedback queue scheduler: random and directed commands,
// a queue-based predictor of the three levels, valid/ready driver and monitor
// depends on tlfqs_pkg and three_level_feedback_queue_scheduler
module three_level_feedback_queue_scheduler_tb;
    import tlfqs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct {
        logic [7:0]         id;
        logic [7:0]         prio;
        logic signed [31:0] key;
        logic [31:0]        stamp;
    } sched_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    three_level_feedback_queue_scheduler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow of the three levels and the registers
    sched_entry_t lvl [3][$];
    logic [7:0]   low_thr, high_thr, age_step;
    logic [15:0]  age_lim;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        quiet = 1'b0;       // no idling near the end
    bit        hold_results = 1'b0; // long receiver hold-off
    int        send_gap = 0;
    int        recv_gap = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // true when a belongs strictly ahead of b in a sorted level
    function automatic bit ahead_of(input int lv, input sched_entry_t a, input sched_entry_t b);
        if (lv == 0 && a.key != b.key) return a.key < b.key;
        if (lv == 1 && a.prio != b.prio) return a.prio > b.prio;
        return a.id < b.id;
    endfunction

    function automatic bit place_sorted(input int lv, input sched_entry_t e);
        int pos;
        if (lvl[lv].size() >= DEPTH) return 0;
        pos = lvl[lv].size();
        foreach (lvl[lv][i]) begin
            if (ahead_of(lv, e, lvl[lv][i])) begin
                pos = i;
                break;
            end
        end
        lvl[lv].insert(pos, e);
        return 1;
    endfunction

    function automatic bit try_age(ref sched_entry_t e, input logic [31:0] now);
        logic [31:0] waited;
        int p;
        waited = now - e.stamp;
        if (waited <= {16'd0, age_lim}) return 0;
        p = int'(e.prio) + int'(age_step);
        e.prio = (p > 255) ? 8'd255 : p[7:0];
        e.stamp = now;
        return 1;
    endfunction

    function automatic void run_aging(input logic [31:0] now);
        sched_entry_t walk [$];
        sched_entry_t held [$];
        sched_entry_t e;
        walk = lvl[2];
        lvl[2].delete();
        foreach (walk[i]) begin
            e = walk[i];
            if (try_age(e, now)) begin
                if (!(e.prio > low_thr && place_sorted(1, e))) held.push_back(e);
            end else begin
                lvl[2].push_back(e);
            end
        end
        foreach (held[i]) lvl[2].push_back(held[i]);
        walk = lvl[1];
        lvl[1].delete();
        foreach (walk[i]) begin
            e = walk[i];
            if (try_age(e, now) && e.prio > high_thr && place_sorted(0, e)) continue;
            void'(place_sorted(1, e));
        end
    endfunction

    function automatic out_item_t schedule_step(input in_item_t it);
        out_item_t r;
        sched_entry_t e;
        bit ok;
        r = '0;
        case (it.opcode)
            OP_READY: begin
                e.id = it.thread_id;
                e.prio = it.priority_req;
                e.key = it.remaining_burst;
                e.stamp = it.now_tick;
                if (e.prio > high_thr) ok = place_sorted(0, e);
                else if (e.prio > low_thr) ok = place_sorted(1, e);
                else if (lvl[2].size() < DEPTH) begin
                    lvl[2].push_back(e);
                    ok = 1;
                end else ok = 0;
                if (!ok) r.status = STAT_FULL;
            end
            OP_PICK: begin
                r.status = STAT_EMPTY;
                for (int lv = 0; lv < 3; lv++) begin
                    if (lvl[lv].size() != 0) begin
                        e = lvl[lv].pop_front();
                        r.picked_id = e.id;
                        r.picked_level = 2'(lv + 1);
                        r.status = STAT_DONE;
                        break;
                    end
                end
            end
            OP_AGE: run_aging(it.now_tick);
            default: ;
        endcase
        return r;
    endfunction

    // driver: one item offered at a time, random idle bursts between items
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(schedule_step(s_data));
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted result with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_data.status, want.status));
                    if (m_data.picked_id !== want.picked_id)
                        report_mismatch($sformatf("picked_id %0d, predicted %0d",
                                                  m_data.picked_id, want.picked_id));
                    if (m_data.picked_level !== want.picked_level)
                        report_mismatch($sformatf("picked_level %0d, predicted %0d",
                                                  m_data.picked_level, want.picked_level));
                end
            end
            if (hold_results) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 17);
            end
        end
    end

    // timeout guard
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        // every accepted item has already returned its result here
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOW_THR:  low_thr = val[7:0];
            CFG_HIGH_THR: high_thr = val[7:0];
            CFG_AGE_LIM:  age_lim = val;
            default:      age_step = val[7:0];
        endcase
    endtask

    function automatic in_item_t make_item(input logic [1:0] op, input logic [7:0] id,
                                           input logic [7:0] pr, input logic [31:0] burst,
                                           input logic [31:0] now);
        in_item_t it;
        it.opcode = op;
        it.thread_id = id;
        it.priority_req = pr;
        it.remaining_burst = burst;
        it.now_tick = now;
        return it;
    endfunction

    // mostly ready/pick traffic with occasional aging; ticks advance slowly
    task automatic queue_random(input int count, ref logic [31:0] now);
        logic [1:0]  op;
        logic [31:0] burst;
        logic [7:0]  id;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            op = (k < 55) ? OP_READY : (k < 85) ? OP_PICK : (k < 98) ? OP_AGE : 2'd3;
            now = now + $urandom_range(0, 400);
            if ($urandom_range(0, 30) == 0) now = $urandom;
            burst = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20) << 8;
            id = 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15));
            pending_items.push_back(make_item(op, id, 8'($urandom), burst, now));
        end
    endtask

    initial begin
        logic [31:0] now;
        low_thr = LOW_THR_RST;
        high_thr = HIGH_THR_RST;
        age_lim = AGE_LIM_RST;
        age_step = AGE_STEP_RST;
        for (int d = 0; d < 3; d++) lvl[d].delete();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pick, each level, ties, extremes, unknown opcode, aging, full level
        now = 32'd100;
        pending_items.push_back(make_item(OP_PICK, 8'd0, 8'd0, 32'd0, now));
        pending_items.push_back(make_item(OP_READY, 8'd5, 8'd255, 32'h8000_0000, now));
        pending_items.push_back(make_item(OP_READY, 8'd3, 8'd200, 32'h7fff_ffff, now));
        pending_items.push_back(make_item(OP_READY, 8'd2, 8'd200, 32'h7fff_ffff, now));
        pending_items.push_back(make_item(OP_READY, 8'd9, 8'd99, 32'd0, now));
        pending_items.push_back(make_item(OP_READY, 8'd7, 8'd50, 32'd0, now));
        pending_items.push_back(make_item(OP_READY, 8'd255, 8'd49, 32'hffff_ffff, now));
        pending_items.push_back(make_item(OP_READY, 8'd0, 8'd0, 32'd0, now));
        pending_items.push_back(make_item(2'd3, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
        pending_items.push_back(make_item(OP_AGE, 8'd0, 8'd0, 32'd0, now + 32'd1500));
        pending_items.push_back(make_item(OP_AGE, 8'd0, 8'd0, 32'd0, now + 32'd1501));
        pending_items.push_back(make_item(OP_AGE, 8'd0, 8'd0, 32'd0, 32'd50));
        for (int i = 0; i < 8; i++)
            pending_items.push_back(make_item(OP_PICK, 8'd0, 8'd0, 32'd0, now));
        for (int i = 0; i < DEPTH + 2; i++)
            pending_items.push_back(make_item(OP_READY, i[7:0], 8'd10, 32'd0, now));
        wait_drained();

        // receiver holds off while the sender keeps offering items
        hold_results = 1'b1;
        queue_random(60, now);
        repeat (3000) @(posedge aclk);
        hold_results = 1'b0;
        queue_random(300, now);
        wait_drained();

        // inverted thresholds, fast aging, saturating step
        write_register(CFG_LOW_THR, 16'd200);
        write_register(CFG_HIGH_THR, 16'd60);
        write_register(CFG_AGE_LIM, 16'd0);
        write_register(CFG_AGE_STEP, 16'd255);
        queue_random(300, now);
        wait_drained();

        // extremes: new items go to level 2 or 3 with no aging gain, then to level 1 or 3
        write_register(CFG_LOW_THR, 16'd0);
        write_register(CFG_HIGH_THR, 16'd255);
        write_register(CFG_AGE_LIM, 16'hffff);
        write_register(CFG_AGE_STEP, 16'd0);
        queue_random(250, now);
        wait_drained();

        write_register(CFG_LOW_THR, 16'd255);
        write_register(CFG_HIGH_THR, 16'd0);
        write_register(CFG_AGE_LIM, 16'd300);
        write_register(CFG_AGE_STEP, 16'd40);
        queue_random(250, now);
        wait_drained();

        write_register(CFG_LOW_THR, 16'd80);
        write_register(CFG_HIGH_THR, 16'd170);
        write_register(CFG_AGE_LIM, 16'd700);
        write_register(CFG_AGE_STEP, 16'd30);
        queue_random(200, now);
        while (pending_items.size() > 60) @(posedge aclk);
        quiet = 1'b1;
        queue_random(100, now);
        wait_drained();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
design/tlfqs_pkg.sv
design/tlfqs_ram.sv
design/tlfqs_unit.sv
design/three_level_feedback_queue_scheduler.sv
tb/three_level_feedback_queue_scheduler_tb.sv
